>>> rtl/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types and codes for the sorted priority queue: command and result
// beats, queue entries, the cell control broadcast and the cell link.
// ============================================================================
package spq_pkg;

    localparam int PRIO_W = 32;
    localparam int PAY_W  = 16;
    localparam int OCC_W  = 7;

    // operation codes
    localparam logic [2:0] MODE_INS_AFTER  = 3'd0;
    localparam logic [2:0] MODE_INS_BEFORE = 3'd1;
    localparam logic [2:0] MODE_POP_HEAD   = 3'd2;
    localparam logic [2:0] MODE_POP_TAIL   = 3'd3;
    localparam logic [2:0] MODE_FIND       = 3'd4;
    localparam logic [2:0] MODE_REMOVE     = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [PRIO_W-1:0] priority_req;
        logic [PAY_W-1:0]  payload;
    } spq_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAY_W-1:0]  out_payload;
        logic [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]  occupancy;
    } spq_result_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAY_W-1:0]  payload;
    } spq_entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [2:0]        mode;
        logic [PRIO_W-1:0] key;
        logic [PAY_W-1:0]  tag;
        logic              do_insert;
        logic              ins_after;
        logic              do_pop_head;
        logic              do_remove;
    } spq_ctrl_t;

    // what one cell hands to its right neighbor
    typedef struct packed {
        spq_entry_t entry;
        logic       ge;
        logic       eq;
    } spq_link_t;

endpackage

>>> rtl/spq_cell.sv
// ============================================================================
// spq_cell
// One queue slot. Compares its entry against the broadcast key/tag and
// shifts toward the tail on insert or toward the head on pop/remove.
// ============================================================================
module spq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  spq_pkg::spq_ctrl_t  ctrl,
    input  logic [CNT_W-1:0]    count,
    input  spq_pkg::spq_link_t  left,
    input  spq_pkg::spq_entry_t right_entry,
    input  logic                pre_match,
    output spq_pkg::spq_link_t  link,
    output logic                match,
    output logic                sel,
    output spq_pkg::spq_entry_t sel_entry
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;
    spq_entry_t new_entry;
    logic       valid;
    logic       last;

    assign valid     = count > CNT_W'(IDX);
    assign last      = count == CNT_W'(IDX + 1);
    assign new_entry = '{prio: ctrl.key, payload: ctrl.tag};

    // local compares; empty slots sort as +infinity
    always_comb
    begin
        link.entry = entry_reg;
        link.eq    = valid && (entry_reg.prio == ctrl.key);
        if (ctrl.ins_after)
            link.ge = !valid || (entry_reg.prio > ctrl.key);
        else
            link.ge = !valid || (entry_reg.prio >= ctrl.key);
        match = valid && (entry_reg.payload == ctrl.tag);
    end

    // read select for pop head, pop tail and find
    always_comb
    begin
        case (ctrl.mode)
            MODE_POP_HEAD: sel = valid && (IDX == 0);
            MODE_POP_TAIL: sel = last;
            MODE_FIND:     sel = link.eq && !left.eq;
            default:       sel = 1'b0;
        endcase
        sel_entry = sel ? entry_reg : '0;
    end

    // shift control
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert)
        begin
            if (left.ge)
                entry_next = left.entry;
            else if (link.ge)
                entry_next = new_entry;
        end
        else if (ctrl.do_pop_head || (ctrl.do_remove && pre_match))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/sorted_priority_queue_top.sv
// ============================================================================
// sorted_priority_queue_top
// Sorted queue of (priority, payload) entries held in a row of cells.
// ============================================================================
// Throughput: one command per cycle; busy is always low. Each command is
//   registered, then executed across all cells together.
// Done and the result beat are registered in the execute stage.
// Reset clears the entry count and the pipeline valids; entry storage is
//   not cleared and is only read below the count. Results cannot be stalled.
module sorted_priority_queue_top #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  spq_pkg::spq_cmd_t   cmd,
    output logic                done,
    output spq_pkg::spq_result_t result
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL   = $clog2(DEPTH);

    spq_cmd_t         cmd_reg;
    logic             cmd_vld_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    spq_result_t      result_reg;
    spq_result_t      result_next;
    logic             done_reg;

    spq_ctrl_t        ctrl;
    spq_link_t        link    [DEPTH];
    spq_link_t        left    [DEPTH];
    spq_entry_t       right_e [DEPTH];
    spq_entry_t       sel_e   [DEPTH];
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] pre_lvl [LVL+1];
    logic [DEPTH-1:0] pre_match;
    spq_entry_t       rd_entry;
    logic             full;
    logic             empty;
    logic             rm_found;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign rm_found = pre_match[DEPTH-1];

    // control broadcast to the cells
    always_comb
    begin
        ctrl.mode        = cmd_reg.mode;
        ctrl.key         = cmd_reg.priority_req;
        ctrl.tag         = cmd_reg.payload;
        ctrl.ins_after   = cmd_reg.mode == MODE_INS_AFTER;
        ctrl.do_insert   = cmd_vld_reg && !full &&
                           (cmd_reg.mode == MODE_INS_AFTER ||
                            cmd_reg.mode == MODE_INS_BEFORE);
        ctrl.do_pop_head = cmd_vld_reg && !empty && (cmd_reg.mode == MODE_POP_HEAD);
        ctrl.do_remove   = cmd_vld_reg && (cmd_reg.mode == MODE_REMOVE);
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left[i] = '{entry: link[i].entry, ge: 1'b0, eq: 1'b0};
        end
        else
        begin : g_mid
            assign left[i] = link[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e[i] = link[i].entry;
        end
        else
        begin : g_inner
            assign right_e[i] = link[i+1].entry;
        end

        spq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left        (left[i]),
            .right_entry (right_e[i]),
            .pre_match   (pre_match[i]),
            .link        (link[i]),
            .match       (match[i]),
            .sel         (sel[i]),
            .sel_entry   (sel_e[i])
        );
    end

    // prefix OR of payload matches: cells at and after the first match close up
    always_comb
    begin
        pre_lvl[0] = match;
        for (int k = 0; k < LVL; k++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i >= (1 << k))
                    pre_lvl[k+1][i] = pre_lvl[k][i] | pre_lvl[k][i-(1<<k)];
                else
                    pre_lvl[k+1][i] = pre_lvl[k][i];
            end
        end
        pre_match = pre_lvl[LVL];
    end

    // one-hot read of the selected cell
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_entry = rd_entry | sel_e[i];
        end
    end

    // status, count and result beat
    always_comb
    begin
        count_next               = count_reg;
        result_next.status       = STAT_OK;
        result_next.out_payload  = '0;
        result_next.out_priority = '0;
        case (cmd_reg.mode)
            MODE_INS_AFTER, MODE_INS_BEFORE:
            begin
                if (full)
                    result_next.status = STAT_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            MODE_POP_HEAD, MODE_POP_TAIL:
            begin
                if (empty)
                    result_next.status = STAT_EMPTY;
                else
                begin
                    count_next               = count_reg - CNT_W'(1);
                    result_next.out_payload  = rd_entry.payload;
                    result_next.out_priority = rd_entry.prio;
                end
            end
            MODE_FIND:
            begin
                if (|sel)
                begin
                    result_next.out_payload  = rd_entry.payload;
                    result_next.out_priority = rd_entry.prio;
                end
                else
                    result_next.status = STAT_EMPTY;
            end
            MODE_REMOVE:
            begin
                if (rm_found)
                    count_next = count_reg - CNT_W'(1);
                else
                    result_next.status = STAT_MISSING;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        occ_wide              = {{OCC_W{1'b0}}, count_next};
        result_next.occupancy = occ_wide[OCC_W-1:0];
    end

    // command stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_vld_reg <= 1'b0;
        else
            cmd_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
    end

    // execute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_vld_reg;
            if (cmd_vld_reg)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_vld_reg)
            result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_vld_reg |=> done)
        else $error("executed command gave no result beat");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel))
        else $error("more than one cell selected for read");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue by one");
`endif

endmodule
